FILE: rtl/tlbfl_pkg.sv
// shared widths, codes and the cell control struct of the translation buffer
package tlbfl_pkg;

    localparam int PID_W   = 8;
    localparam int PAGE_W  = 32;
    localparam int FRAME_W = 32;
    localparam int CAP_W   = 6;

    localparam int DEF_MAX_ENTRIES = 32;

    // configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_IN_USE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_MODE = 1'd1;

    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    localparam logic MODE_FIFO = 1'b0;
    localparam logic MODE_LRU  = 1'b1;

    typedef struct packed {
        logic capture;     // register the tag compare of a new word
        logic hit_upd;     // lookup hit: make matching entry the most recent by rank
        logic ins_upd;     // insert: append, shifting past a victim
        logic evict;       // this insert removes one entry
        logic lru;         // victim is the least recently used entry
    } cell_ctl_t;

endpackage

FILE: rtl/tlbfl_cell.sv
// one entry of the translation buffer with its compare and shift logic
module tlbfl_cell #(
    parameter int MAX_ENTRIES = tlbfl_pkg::DEF_MAX_ENTRIES,
    parameter int IDX         = 0
) (
    input  logic                                       clk,
    input  tlbfl_pkg::cell_ctl_t                       ctl,
    input  logic [$clog2(MAX_ENTRIES+1)-1:0]           count,
    input  logic [$clog2(MAX_ENTRIES+1)-1:0]           new_idx,
    input  logic [$clog2(MAX_ENTRIES+1)-1:0]           threshold,
    input  logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] lru_rank,
    input  logic [tlbfl_pkg::PID_W-1:0]                key_pid,
    input  logic [tlbfl_pkg::PAGE_W-1:0]               key_page,
    input  logic [tlbfl_pkg::FRAME_W-1:0]              new_frame,
    // priority chain from the older neighbor
    input  logic                                       found_in,
    output logic                                       found_out,
    input  logic [tlbfl_pkg::FRAME_W-1:0]              frame_in,
    output logic [tlbfl_pkg::FRAME_W-1:0]              frame_out,
    input  logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] hrank_in,
    output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] hrank_out,
    input  logic                                       shift_in,
    output logic                                       shift_out,
    // contents of the newer neighbor
    input  logic [tlbfl_pkg::PID_W-1:0]                nb_pid,
    input  logic [tlbfl_pkg::PAGE_W-1:0]               nb_page,
    input  logic [tlbfl_pkg::FRAME_W-1:0]              nb_frame,
    input  logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] nb_rank,
    // own contents toward the older neighbor
    output logic [tlbfl_pkg::PID_W-1:0]                my_pid,
    output logic [tlbfl_pkg::PAGE_W-1:0]               my_page,
    output logic [tlbfl_pkg::FRAME_W-1:0]              my_frame,
    output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] my_rank
);

    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    logic [tlbfl_pkg::PID_W-1:0]   pid_reg,   pid_next;
    logic [tlbfl_pkg::PAGE_W-1:0]  page_reg,  page_next;
    logic [tlbfl_pkg::FRAME_W-1:0] frame_reg, frame_next;
    logic [RANK_W-1:0]             rank_reg,  rank_next;
    logic                          match_reg, match_next;
    logic                          valid;
    logic                          first;
    logic                          is_victim;
    logic                          shift;
    logic                          own_bump;
    logic                          nb_bump;

    assign valid = CNT_W'(IDX) < count;

    assign match_next = valid && (pid_reg == key_pid) && (page_reg == key_page);

    // first matching entry counted from the oldest
    assign first     = match_reg && !found_in;
    assign found_out = found_in || match_reg;
    assign frame_out = frame_in | (first ? frame_reg : '0);
    assign hrank_out = hrank_in | (first ? rank_reg : '0);

    assign is_victim = ctl.evict && (ctl.lru ? (valid && (rank_reg == lru_rank))
                                             : (IDX == 0));
    assign shift     = shift_in || is_victim;
    assign shift_out = shift;

    assign own_bump = CNT_W'(rank_reg) < threshold;
    assign nb_bump  = CNT_W'(nb_rank) < threshold;

    always_comb
    begin
        pid_next   = pid_reg;
        page_next  = page_reg;
        frame_next = frame_reg;
        rank_next  = rank_reg;
        if (ctl.hit_upd)
        begin
            if (first)
                rank_next = '0;
            else if (valid && own_bump)
                rank_next = rank_reg + RANK_W'(1);
        end
        else if (ctl.ins_upd)
        begin
            if (CNT_W'(IDX) == new_idx)
            begin
                pid_next   = key_pid;
                page_next  = key_page;
                frame_next = new_frame;
                rank_next  = '0;
            end
            else if (shift)
            begin
                pid_next   = nb_pid;
                page_next  = nb_page;
                frame_next = nb_frame;
                rank_next  = nb_bump ? nb_rank + RANK_W'(1) : nb_rank;
            end
            else if (own_bump)
                rank_next = rank_reg + RANK_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        pid_reg   <= pid_next;
        page_reg  <= page_next;
        frame_reg <= frame_next;
        rank_reg  <= rank_next;
        if (ctl.capture)
            match_reg <= match_next;
    end

    assign my_pid   = pid_reg;
    assign my_page  = page_reg;
    assign my_frame = frame_reg;
    assign my_rank  = rank_reg;

endmodule

FILE: rtl/tlb_fifo_lru_lookup_insert.sv
// top level of the fully associative translation buffer with fifo or lru replacement
//
// input stream: one word per lookup or insert; tuser carries the command
// (0 lookup, 1 insert), tdata the process id, page and frame.
// output stream: one word per input word, tdata the frame on a hit (else 0),
// tuser the hit and evicted flags.
// configuration: cfg_index 0 writes entries_in_use, 1 writes replacement_mode;
// cfg_ready is always high, writes may come only while no word is in flight.
//
// entries sit in a row of cells in insertion order, oldest in cell 0. the
// accepting edge registers the tag compare in every cell; the update step after
// it resolves the first match along the cell chain, updates recency ranks,
// shifts cells past a victim and appends the new entry, once the output
// register is free. the result word is registered at the end of the update step.
// the compare and update steps of one word do not overlap with the next word:
// a new input word is taken only while no word is in the update step.
// a stalled output holds its word; the next input word is taken meanwhile
// and waits in the update step until the output register frees up.
// reset empties the buffer and sets capacity 32 and fifo replacement.
module tlb_fifo_lru_lookup_insert #(
    parameter int MAX_ENTRIES = tlbfl_pkg::DEF_MAX_ENTRIES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [71:0]                         s_axis_tdata,  // process_id, page_number, frame_number
    input  logic                                s_axis_tuser,  // command
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [31:0]                         m_axis_tdata,  // frame_out
    output logic [1:0]                          m_axis_tuser,  // hit, evicted
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tlbfl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tlbfl_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CMP_W  = (CNT_W > tlbfl_pkg::CAP_W) ? CNT_W : tlbfl_pkg::CAP_W;
    localparam int PID_W   = tlbfl_pkg::PID_W;
    localparam int PAGE_W  = tlbfl_pkg::PAGE_W;
    localparam int FRAME_W = tlbfl_pkg::FRAME_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                          state_reg, state_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [tlbfl_pkg::CAP_W-1:0]   cap_reg;
    logic                          mode_reg;
    logic                          cmd_reg;
    logic [PID_W-1:0]              pid_reg;
    logic [PAGE_W-1:0]             page_reg;
    logic [FRAME_W-1:0]            frame_reg;
    logic                          out_valid_reg, out_valid_next;
    logic                          out_hit_reg;
    logic                          out_evict_reg;
    logic [FRAME_W-1:0]            out_frame_reg;

    logic                          in_fire;
    logic                          go;
    logic                          is_insert;
    logic                          evict;
    logic                          hit;
    logic [CMP_W-1:0]              cap_eff;
    logic [CMP_W-1:0]              cap_lim;
    logic [CNT_W-1:0]              new_idx;
    logic [CNT_W-1:0]              threshold;
    logic [RANK_W-1:0]             lru_rank;
    logic [PID_W-1:0]              key_pid;
    logic [PAGE_W-1:0]             key_page;
    tlbfl_pkg::cell_ctl_t          ctl;

    // chain nets, index MAX_ENTRIES is the open end past the newest cell
    logic                          found_c [0:MAX_ENTRIES];
    logic [FRAME_W-1:0]            frame_c [0:MAX_ENTRIES];
    logic [RANK_W-1:0]             hrank_c [0:MAX_ENTRIES];
    logic                          shift_c [0:MAX_ENTRIES];
    logic [PID_W-1:0]              pid_c   [0:MAX_ENTRIES];
    logic [PAGE_W-1:0]             page_c  [0:MAX_ENTRIES];
    logic [FRAME_W-1:0]            efrm_c  [0:MAX_ENTRIES];
    logic [RANK_W-1:0]             rank_c  [0:MAX_ENTRIES];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign go            = (state_reg == ST_EXEC) && (!out_valid_reg || m_axis_tready);
    assign cfg_ready     = 1'b1;

    // compare keys come straight from the port in the capture cycle
    assign key_pid  = in_fire ? s_axis_tdata[7:0]  : pid_reg;
    assign key_page = in_fire ? s_axis_tdata[39:8] : page_reg;

    always_comb
    begin
        cap_eff = (cap_reg == '0) ? CMP_W'(1) : CMP_W'(cap_reg);
        cap_lim = (cap_eff > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES) : cap_eff;
    end

    assign is_insert = (cmd_reg == tlbfl_pkg::CMD_INSERT);
    assign evict     = is_insert && (CMP_W'(count_reg) >= cap_lim) && (count_reg != '0);
    assign hit       = !is_insert && found_c[MAX_ENTRIES];
    assign lru_rank  = RANK_W'(count_reg - CNT_W'(1));
    assign new_idx   = evict ? count_reg - CNT_W'(1) : count_reg;

    always_comb
    begin
        if (!is_insert)
            threshold = CNT_W'(hrank_c[MAX_ENTRIES]);
        else if (!evict)
            threshold = count_reg;
        else if (mode_reg == tlbfl_pkg::MODE_LRU)
            threshold = CNT_W'(lru_rank);
        else
            threshold = CNT_W'(rank_c[0]);
    end

    always_comb
    begin
        ctl.capture = in_fire;
        ctl.hit_upd = go && hit;
        ctl.ins_upd = go && is_insert;
        ctl.evict   = evict;
        ctl.lru     = (mode_reg == tlbfl_pkg::MODE_LRU);
    end

    assign found_c[0] = 1'b0;
    assign frame_c[0] = '0;
    assign hrank_c[0] = '0;
    assign shift_c[0] = 1'b0;
    assign pid_c[MAX_ENTRIES]  = '0;
    assign page_c[MAX_ENTRIES] = '0;
    assign efrm_c[MAX_ENTRIES] = '0;
    assign rank_c[MAX_ENTRIES] = '0;

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        logic [PID_W-1:0]   own_pid;
        logic [PAGE_W-1:0]  own_page;
        logic [FRAME_W-1:0] own_frame;
        logic [RANK_W-1:0]  own_rank;

        tlbfl_cell #(
            .MAX_ENTRIES (MAX_ENTRIES),
            .IDX         (i)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .count     (count_reg),
            .new_idx   (new_idx),
            .threshold (threshold),
            .lru_rank  (lru_rank),
            .key_pid   (key_pid),
            .key_page  (key_page),
            .new_frame (frame_reg),
            .found_in  (found_c[i]),
            .found_out (found_c[i+1]),
            .frame_in  (frame_c[i]),
            .frame_out (frame_c[i+1]),
            .hrank_in  (hrank_c[i]),
            .hrank_out (hrank_c[i+1]),
            .shift_in  (shift_c[i]),
            .shift_out (shift_c[i+1]),
            .nb_pid    (pid_c[i+1]),
            .nb_page   (page_c[i+1]),
            .nb_frame  (efrm_c[i+1]),
            .nb_rank   (rank_c[i+1]),
            .my_pid    (own_pid),
            .my_page   (own_page),
            .my_frame  (own_frame),
            .my_rank   (own_rank)
        );

        assign pid_c[i]  = own_pid;
        assign page_c[i] = own_page;
        assign efrm_c[i] = own_frame;
        assign rank_c[i] = own_rank;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        if (m_axis_tready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (go)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    if (is_insert && !evict)
                        count_next = count_reg + CNT_W'(1);
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cap_reg       <= tlbfl_pkg::CAP_RESET;
            mode_reg      <= tlbfl_pkg::MODE_FIFO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    tlbfl_pkg::REG_ENTRIES_IN_USE:   cap_reg  <= cfg_data;
                    tlbfl_pkg::REG_REPLACEMENT_MODE: mode_reg <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg   <= s_axis_tuser;
            pid_reg   <= s_axis_tdata[7:0];
            page_reg  <= s_axis_tdata[39:8];
            frame_reg <= s_axis_tdata[71:40];
        end
        if (go)
        begin
            out_hit_reg   <= hit;
            out_evict_reg <= evict;
            out_frame_reg <= hit ? frame_c[MAX_ENTRIES] : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_frame_reg;
    assign m_axis_tuser  = {out_evict_reg, out_hit_reg};

endmodule
